/* sv/poel_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// poel_pkg
// Word types, operation codes and status codes shared by the eviction list.
// ----------------------------------------------------------------------------
package poel_pkg;

    localparam int FIELD_W = 32;
    localparam int TOTAL_W = 38;
    localparam int MODE_W  = 3;
    localparam int STAT_W  = 3;

    typedef logic [FIELD_W-1:0] t_field;
    typedef logic [TOTAL_W-1:0] t_total;
    typedef logic [MODE_W-1:0]  t_mode;
    typedef logic [STAT_W-1:0]  t_status;

    // operation codes
    localparam t_mode MODE_INSERT = 3'd0;
    localparam t_mode MODE_REMOVE = 3'd1;
    localparam t_mode MODE_TOUCH  = 3'd2;
    localparam t_mode MODE_POP    = 3'd3;
    localparam t_mode MODE_BELOW  = 3'd4;

    // status codes
    localparam t_status ST_OK      = 3'd0;
    localparam t_status ST_PRESENT = 3'd1;
    localparam t_status ST_ABSENT  = 3'd2;
    localparam t_status ST_EMPTY   = 3'd3;
    localparam t_status ST_FULL    = 3'd4;

    typedef struct packed {
        t_mode  mode;
        t_field entry_key;
        t_field entry_priority;
        t_field entry_bytes;
    } t_in_word;

    typedef struct packed {
        t_field  moved_bytes;
        t_field  popped_key;
        t_total  sum_below;
        t_total  total_bytes;
        logic    is_empty;
        t_status status;
    } t_out_word;

endpackage
`default_nettype wire

/* sv/poel_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// poel_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module poel_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* sv/priority_ordered_eviction_list.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// priority_ordered_eviction_list
// Bounded table of cache entries (key, priority, size) with insert, remove,
// touch, pop of the first entry in eviction order, and size-below queries.
// ----------------------------------------------------------------------------
// usage
//   input channel: i_in_valid / o_in_ready / i_in_word, one operation per word
//   output channel: o_out_valid / i_out_ready / o_out_word, one result per word
//   entries sit unordered in one RAM, slots 0 .. count-1; removal moves the
//   last slot into the hole, so only written slots are ever read
//   every operation scans all stored entries through one compare/add unit,
//   one RAM read per cycle, tracking key match, first entry in eviction
//   order (priority asc, size desc, key asc) and the sum below a bound
//   a word is accepted only in the idle state, so each operation's scan and
//   final step finish before the next word is taken, which can happen once
//   the result is loaded; the scan time grows with the number of stored
//   entries, as the RAM read port gives one entry per cycle
//   the result sits in an output register; a new word is accepted while it
//   waits, and the block only stalls in its final step if the receiver has
//   not taken the previous result yet
//   reset (synchronous, active low) empties the table and zeroes the total;
//   no clearing pass is needed
// ----------------------------------------------------------------------------
module priority_ordered_eviction_list #(
    parameter int CAPACITY      = 64,
    parameter int KEY_BITS      = 32,
    parameter int PRIORITY_BITS = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire poel_pkg::t_in_word   i_in_word,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output poel_pkg::t_out_word       o_out_word
);

    // stored widths; input fields are 32 bits, so wider keys add nothing
    localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
    localparam int PW = (PRIORITY_BITS < 32) ? PRIORITY_BITS : 32;
    localparam int BW = 32;
    localparam int EW = KW + PW + BW;
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef logic [CW-1:0] t_cnt;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_ACT  = 2'd2;

    // control
    logic [1:0]          r_state, n_state;
    t_cnt                r_cnt, n_cnt;
    poel_pkg::t_total    r_total, n_total;
    t_cnt                r_idx, n_idx;
    logic                r_pv, n_pv;
    logic [AW-1:0]       r_pidx, n_pidx;
    logic                r_out_valid, n_out_valid;

    // latched operation
    poel_pkg::t_mode     r_mode, n_mode;
    logic [KW-1:0]       r_key, n_key;
    logic [PW-1:0]       r_prio, n_prio;
    logic [BW-1:0]       r_bytes, n_bytes;

    // scan results
    logic                r_found, n_found;
    logic [AW-1:0]       r_fidx, n_fidx;
    logic [BW-1:0]       r_fbytes, n_fbytes;
    logic                r_have_best, n_have_best;
    logic [KW-1:0]       r_bkey, n_bkey;
    logic [PW-1:0]       r_bprio, n_bprio;
    logic [BW-1:0]       r_bbytes, n_bbytes;
    logic [AW-1:0]       r_bidx, n_bidx;
    poel_pkg::t_total    r_sum, n_sum;
    logic [EW-1:0]       r_last, n_last;

    poel_pkg::t_out_word r_out, n_out;

    // ram port
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [EW-1:0]       ram_wdata;
    logic                ram_re;
    logic [EW-1:0]       ram_rdata;

    // entry read back from the ram
    logic [KW-1:0]       d_key;
    logic [PW-1:0]       d_prio;
    logic [BW-1:0]       d_bytes;
    logic                d_before;
    logic                act_go;

    poel_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign d_key   = ram_rdata[EW-1 -: KW];
    assign d_prio  = ram_rdata[BW +: PW];
    assign d_bytes = ram_rdata[BW-1:0];

    // shared order compare: entry read back comes before the best so far
    assign d_before = (d_prio < r_bprio) ||
                      ((d_prio == r_bprio) &&
                       ((d_bytes > r_bbytes) ||
                        ((d_bytes == r_bbytes) && (d_key < r_bkey))));

    // final step waits only while the previous result is still held
    assign act_go = !r_out_valid || i_out_ready;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_total     = r_total;
        n_idx       = r_idx;
        n_pv        = r_pv;
        n_pidx      = r_pidx;
        n_out_valid = r_out_valid;
        n_mode      = r_mode;
        n_key       = r_key;
        n_prio      = r_prio;
        n_bytes     = r_bytes;
        n_found     = r_found;
        n_fidx      = r_fidx;
        n_fbytes    = r_fbytes;
        n_have_best = r_have_best;
        n_bkey      = r_bkey;
        n_bprio     = r_bprio;
        n_bbytes    = r_bbytes;
        n_bidx      = r_bidx;
        n_sum       = r_sum;
        n_last      = r_last;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;
        ram_re      = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode      = i_in_word.mode;
                    n_key       = i_in_word.entry_key[KW-1:0];
                    n_prio      = i_in_word.entry_priority[PW-1:0];
                    n_bytes     = i_in_word.entry_bytes;
                    n_idx       = '0;
                    n_pv        = 1'b0;
                    n_found     = 1'b0;
                    n_have_best = 1'b0;
                    n_sum       = '0;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                // issue one read per cycle
                if (r_idx < r_cnt) begin
                    ram_re = 1'b1;
                    n_pv   = 1'b1;
                    n_pidx = r_idx[AW-1:0];
                    n_idx  = r_idx + 1'b1;
                end else begin
                    n_pv    = 1'b0;
                    n_state = S_ACT;
                end
                // check the entry read last cycle
                if (r_pv) begin
                    if (d_key == r_key) begin
                        n_found  = 1'b1;
                        n_fidx   = r_pidx;
                        n_fbytes = d_bytes;
                    end
                    if (!r_have_best || d_before) begin
                        n_have_best = 1'b1;
                        n_bkey      = d_key;
                        n_bprio     = d_prio;
                        n_bbytes    = d_bytes;
                        n_bidx      = r_pidx;
                    end
                    if (d_prio < r_prio) begin
                        n_sum = r_sum + poel_pkg::t_total'(d_bytes);
                    end
                    if (t_cnt'(r_pidx) == r_cnt - 1'b1) begin
                        n_last = ram_rdata;
                    end
                end
            end
            S_ACT: begin
                if (act_go) begin
                    n_out = '0;
                    case (r_mode)
                        poel_pkg::MODE_INSERT: begin
                            if (r_found) begin
                                n_out.status = poel_pkg::ST_PRESENT;
                            end else if (r_cnt == t_cnt'(CAPACITY)) begin
                                n_out.status = poel_pkg::ST_FULL;
                            end else begin
                                // append at the end of the used slots
                                ram_we            = 1'b1;
                                ram_waddr         = r_cnt[AW-1:0];
                                ram_wdata         = {r_key, r_prio, r_bytes};
                                n_cnt             = r_cnt + 1'b1;
                                n_total           = r_total + poel_pkg::t_total'(r_bytes);
                                n_out.moved_bytes = r_bytes;
                            end
                        end
                        poel_pkg::MODE_REMOVE: begin
                            if (!r_found) begin
                                n_out.status = poel_pkg::ST_ABSENT;
                            end else begin
                                // last slot fills the hole
                                ram_we            = 1'b1;
                                ram_waddr         = r_fidx;
                                ram_wdata         = r_last;
                                n_cnt             = r_cnt - 1'b1;
                                n_total           = r_total - poel_pkg::t_total'(r_fbytes);
                                n_out.moved_bytes = r_fbytes;
                            end
                        end
                        poel_pkg::MODE_TOUCH: begin
                            if (!r_found) begin
                                n_out.status = poel_pkg::ST_ABSENT;
                            end else begin
                                ram_we            = 1'b1;
                                ram_waddr         = r_fidx;
                                ram_wdata         = {r_key, r_prio, r_fbytes};
                                n_out.moved_bytes = r_fbytes;
                            end
                        end
                        poel_pkg::MODE_POP: begin
                            if (r_cnt == '0) begin
                                n_out.status = poel_pkg::ST_EMPTY;
                            end else begin
                                ram_we            = 1'b1;
                                ram_waddr         = r_bidx;
                                ram_wdata         = r_last;
                                n_cnt             = r_cnt - 1'b1;
                                n_total           = r_total - poel_pkg::t_total'(r_bbytes);
                                n_out.moved_bytes = r_bbytes;
                                n_out.popped_key  = poel_pkg::t_field'(r_bkey);
                            end
                        end
                        poel_pkg::MODE_BELOW: begin
                            n_out.sum_below = r_sum;
                        end
                        default: begin
                            n_out.status = poel_pkg::ST_OK;
                        end
                    endcase
                    n_out.total_bytes = n_total;
                    n_out.is_empty    = (n_cnt == '0);
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_total     <= '0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_total     <= n_total;
            r_pv        <= n_pv;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_pidx      <= n_pidx;
        r_mode      <= n_mode;
        r_key       <= n_key;
        r_prio      <= n_prio;
        r_bytes     <= n_bytes;
        r_found     <= n_found;
        r_fidx      <= n_fidx;
        r_fbytes    <= n_fbytes;
        r_have_best <= n_have_best;
        r_bkey      <= n_bkey;
        r_bprio     <= n_bprio;
        r_bbytes    <= n_bbytes;
        r_bidx      <= n_bidx;
        r_sum       <= n_sum;
        r_last      <= n_last;
        r_out       <= n_out;
    end

endmodule
`default_nettype wire

/* sim/tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Drives insert, remove, touch, pop, size-below and spare-opcode words into
// the list under random bursts and output stalls. A shadow table in the bench
// predicts each result word, and every returned word is checked field by field.
// ----------------------------------------------------------------------------
module tb;

    localparam int TABLE_DEPTH  = 64;
    localparam int ITEM_TARGET  = 1750;
    localparam int MAX_REPORTS  = 40;
    localparam int DRILL_ROWS   = 24;
    // opcodes the block leaves unused
    localparam poel_pkg::t_mode MODE_SPARE_LO  = 3'd5;
    localparam poel_pkg::t_mode MODE_SPARE_MID = 3'd6;
    localparam poel_pkg::t_mode MODE_SPARE_HI  = 3'd7;

    typedef struct {
        poel_pkg::t_field key;
        poel_pkg::t_field prio;
        poel_pkg::t_field bytes;
    } t_entry;

    typedef struct {
        poel_pkg::t_in_word  word;
        bit                  typed;
        poel_pkg::t_out_word want;
    } t_drill_row;

    typedef enum {PHASE_FILL, PHASE_DRAIN, PHASE_CHURN} t_phase;

    localparam poel_pkg::t_out_word NO_WANT = '0;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    poel_pkg::t_in_word  in_word   = '0;
    logic                out_ready = 1'b0;
    logic                in_ready;
    logic                out_valid;
    poel_pkg::t_out_word out_word;

    // shadow of the list contents, kept unordered; order is worked out on pop
    t_entry              shadow_entries[$];
    poel_pkg::t_total    shadow_total = '0;
    // result words predicted for accepted words, oldest first
    poel_pkg::t_out_word awaited_words[$];
    poel_pkg::t_out_word want_word;

    int        mismatch_count = 0;
    int        words_sent     = 0;
    int        burst_left     = 1;
    logic [31:0] ready_pattern = '1;
    logic [5:0]  pattern_age   = '0;

    // directed words: empty-table errors, field extremes, ties in the order,
    // zero-size insert and touch, duplicate key, unused opcodes, drain to empty
    t_drill_row drill_rows [DRILL_ROWS] = '{
        '{'{poel_pkg::MODE_POP, 32'h0, 32'h0, 32'h0}, 1'b1,
          '{32'h0, 32'h0, 38'h0, 38'h0, 1'b1, poel_pkg::ST_EMPTY}},
        '{'{poel_pkg::MODE_REMOVE, 32'h5, 32'h0, 32'h0}, 1'b1,
          '{32'h0, 32'h0, 38'h0, 38'h0, 1'b1, poel_pkg::ST_ABSENT}},
        '{'{poel_pkg::MODE_TOUCH, 32'hFFFF_FFFF, 32'h7, 32'h0}, 1'b1,
          '{32'h0, 32'h0, 38'h0, 38'h0, 1'b1, poel_pkg::ST_ABSENT}},
        '{'{poel_pkg::MODE_BELOW, 32'h0, 32'hFFFF_FFFF, 32'h0}, 1'b1,
          '{32'h0, 32'h0, 38'h0, 38'h0, 1'b1, poel_pkg::ST_OK}},
        '{'{MODE_SPARE_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
          '{32'h0, 32'h0, 38'h0, 38'h0, 1'b1, poel_pkg::ST_OK}},
        '{'{poel_pkg::MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
          '{32'hFFFF_FFFF, 32'h0, 38'h0, 38'hFFFF_FFFF, 1'b0, poel_pkg::ST_OK}},
        '{'{poel_pkg::MODE_INSERT, 32'hFFFF_FFFF, 32'h0, 32'h1}, 1'b1,
          '{32'h0, 32'h0, 38'h0, 38'hFFFF_FFFF, 1'b0, poel_pkg::ST_PRESENT}},
        '{'{poel_pkg::MODE_INSERT, 32'h0, 32'h0, 32'h0}, 1'b1,
          '{32'h0, 32'h0, 38'h0, 38'hFFFF_FFFF, 1'b0, poel_pkg::ST_OK}},
        '{'{poel_pkg::MODE_INSERT, 32'h1, 32'h0, 32'h0}, 1'b0, NO_WANT},
        '{'{poel_pkg::MODE_INSERT, 32'h2, 32'h0, 32'h100}, 1'b0, NO_WANT},
        '{'{poel_pkg::MODE_INSERT, 32'h3, 32'h8000_0000, 32'h100}, 1'b0, NO_WANT},
        '{'{poel_pkg::MODE_BELOW, 32'h0, 32'h0, 32'h0}, 1'b0, NO_WANT},
        '{'{poel_pkg::MODE_BELOW, 32'h0, 32'h1, 32'h0}, 1'b0, NO_WANT},
        '{'{poel_pkg::MODE_BELOW, 32'h0, 32'hFFFF_FFFF, 32'h0}, 1'b0, NO_WANT},
        '{'{poel_pkg::MODE_TOUCH, 32'h0, 32'h8000_0000, 32'h0}, 1'b0, NO_WANT},
        '{'{poel_pkg::MODE_TOUCH, 32'h3, 32'h0, 32'h0}, 1'b0, NO_WANT},
        '{'{poel_pkg::MODE_POP, 32'h0, 32'h0, 32'h0}, 1'b0, NO_WANT},
        '{'{MODE_SPARE_LO, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA}, 1'b0, NO_WANT},
        '{'{poel_pkg::MODE_REMOVE, 32'hFFFF_FFFF, 32'h0, 32'h0}, 1'b0, NO_WANT},
        '{'{poel_pkg::MODE_POP, 32'h0, 32'h0, 32'h0}, 1'b0, NO_WANT},
        '{'{poel_pkg::MODE_POP, 32'h0, 32'h0, 32'h0}, 1'b0, NO_WANT},
        '{'{poel_pkg::MODE_POP, 32'h0, 32'h0, 32'h0}, 1'b0, NO_WANT},
        '{'{poel_pkg::MODE_POP, 32'h0, 32'h0, 32'h0}, 1'b1,
          '{32'h0, 32'h0, 38'h0, 38'h0, 1'b1, poel_pkg::ST_EMPTY}},
        '{'{MODE_SPARE_MID, 32'h0, 32'h0, 32'h0}, 1'b0, NO_WANT}
    };

    priority_ordered_eviction_list #(
        .CAPACITY      (TABLE_DEPTH),
        .KEY_BITS      (32),
        .PRIORITY_BITS (32)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // shadow table
    // ------------------------------------------------------------------------

    // eviction order: lowest priority, then largest size, then lowest key
    function automatic bit evicts_first(t_entry a, t_entry b);
        if (a.prio != b.prio) begin
            return a.prio < b.prio;
        end
        if (a.bytes != b.bytes) begin
            return a.bytes > b.bytes;
        end
        return a.key < b.key;
    endfunction

    // applies one word to the shadow table and returns the result word it gives
    function automatic poel_pkg::t_out_word apply_list_op(poel_pkg::t_in_word w);
        poel_pkg::t_out_word r;
        int                  hit;
        int                  head;
        r   = '0;
        hit = -1;
        foreach (shadow_entries[i]) begin
            if (shadow_entries[i].key == w.entry_key) begin
                hit = i;
            end
        end
        case (w.mode)
            poel_pkg::MODE_INSERT: begin
                if (hit >= 0) begin
                    r.status = poel_pkg::ST_PRESENT;
                end else if (shadow_entries.size() >= TABLE_DEPTH) begin
                    r.status = poel_pkg::ST_FULL;
                end else begin
                    shadow_entries.push_back('{w.entry_key, w.entry_priority, w.entry_bytes});
                    shadow_total  = shadow_total + poel_pkg::t_total'(w.entry_bytes);
                    r.moved_bytes = w.entry_bytes;
                end
            end
            poel_pkg::MODE_REMOVE, poel_pkg::MODE_TOUCH: begin
                if (hit < 0) begin
                    r.status = poel_pkg::ST_ABSENT;
                end else begin
                    r.moved_bytes = shadow_entries[hit].bytes;
                    if (w.mode == poel_pkg::MODE_TOUCH) begin
                        shadow_entries[hit].prio = w.entry_priority;
                    end else begin
                        shadow_total = shadow_total
                                     - poel_pkg::t_total'(shadow_entries[hit].bytes);
                        shadow_entries.delete(hit);
                    end
                end
            end
            poel_pkg::MODE_POP: begin
                if (shadow_entries.size() == 0) begin
                    r.status = poel_pkg::ST_EMPTY;
                end else begin
                    head = 0;
                    foreach (shadow_entries[i]) begin
                        if (evicts_first(shadow_entries[i], shadow_entries[head])) begin
                            head = i;
                        end
                    end
                    r.popped_key  = shadow_entries[head].key;
                    r.moved_bytes = shadow_entries[head].bytes;
                    shadow_total  = shadow_total
                                  - poel_pkg::t_total'(shadow_entries[head].bytes);
                    shadow_entries.delete(head);
                end
            end
            poel_pkg::MODE_BELOW: begin
                foreach (shadow_entries[i]) begin
                    if (shadow_entries[i].prio < w.entry_priority) begin
                        r.sum_below = r.sum_below
                                    + poel_pkg::t_total'(shadow_entries[i].bytes);
                    end
                end
            end
            default: begin
            end
        endcase
        r.total_bytes = shadow_total;
        r.is_empty    = (shadow_entries.size() == 0);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // random field values
    // ------------------------------------------------------------------------

    // mostly an existing key when asked, else a fresh random one
    function automatic poel_pkg::t_field pick_key(int hit_pct);
        if (shadow_entries.size() > 0 && $urandom_range(0, 99) < hit_pct) begin
            return shadow_entries[$urandom_range(0, shadow_entries.size() - 1)].key;
        end
        return $urandom;
    endfunction

    // small values give priority ties, extremes at both ends
    function automatic poel_pkg::t_field pick_priority();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3, 4: return $urandom_range(0, 7);
            5: return 32'h8000_0000 + $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    function automatic poel_pkg::t_field pick_bytes();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    // one mixed word, keys mostly aimed at stored entries
    function automatic poel_pkg::t_in_word make_churn_word();
        poel_pkg::t_in_word w;
        int                 roll;
        w.entry_key      = pick_key(80);
        w.entry_priority = pick_priority();
        w.entry_bytes    = pick_bytes();
        roll = $urandom_range(0, 99);
        if (roll < 30) begin
            w.mode      = poel_pkg::MODE_INSERT;
            w.entry_key = pick_key(15);
        end else if (roll < 45) begin
            w.mode = poel_pkg::MODE_REMOVE;
        end else if (roll < 65) begin
            w.mode = poel_pkg::MODE_TOUCH;
        end else if (roll < 77) begin
            w.mode = poel_pkg::MODE_POP;
        end else if (roll < 95) begin
            w.mode = poel_pkg::MODE_BELOW;
            // bound right at or just past a stored priority
            if (shadow_entries.size() > 0 && $urandom_range(0, 1) == 0) begin
                w.entry_priority = shadow_entries[$urandom_range(0,
                    shadow_entries.size() - 1)].prio + $urandom_range(0, 1);
            end
        end else begin
            w.mode = poel_pkg::t_mode'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
        end
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------

    // offers one word, waits for it to be taken, records the predicted result;
    // typed_want replaces the prediction for rows whose result is typed in
    task automatic send_word(poel_pkg::t_in_word w, bit use_typed,
                             poel_pkg::t_out_word typed_want);
        poel_pkg::t_out_word predicted;
        int                  gap;
        in_word  <= w;
        in_valid <= 1'b1;
        do begin
            @(posedge clk);
        end while (!in_ready);
        predicted = apply_list_op(w);
        awaited_words.push_back(use_typed ? typed_want : predicted);
        words_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            // end of burst: random gap, occasionally none
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 16);
        end
    endtask

    task automatic send_random(poel_pkg::t_in_word w);
        send_word(w, 1'b0, NO_WANT);
    endtask

    // hold the input until every result word has come back
    task automatic wait_quiet();
        in_valid <= 1'b0;
        do begin
            @(posedge clk);
        end while (awaited_words.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------------

    task automatic report_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch at %0t: %s", $time, what);
        end
    endtask

    task automatic check_field(string name, poel_pkg::t_total got,
                               poel_pkg::t_total want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
        end
    endtask

    // receiver stalls on a rotating 32-bit pattern, reloaded whenever the 6-bit
    // pattern age counter wraps; some patterns are all ones, some mostly stalls
    always @(posedge clk) begin
        pattern_age <= pattern_age + 6'd1;
        if (pattern_age == '0) begin
            case ($urandom_range(0, 3))
                0: ready_pattern <= '1;
                1: ready_pattern <= $urandom | 32'h1;
                2: ready_pattern <= ($urandom & $urandom) | 32'h1;
                default: ready_pattern <= $urandom | $urandom;
            endcase
        end else begin
            ready_pattern <= {ready_pattern[0], ready_pattern[31:1]};
        end
        out_ready <= ready_pattern[0];
    end

    // compare each taken result word with the oldest prediction
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (awaited_words.size() == 0) begin
                report_mismatch("result word with nothing awaited");
            end else begin
                want_word = awaited_words[0];
                awaited_words.delete(0);
                check_field("moved_bytes", poel_pkg::t_total'(out_word.moved_bytes),
                            poel_pkg::t_total'(want_word.moved_bytes));
                check_field("popped_key", poel_pkg::t_total'(out_word.popped_key),
                            poel_pkg::t_total'(want_word.popped_key));
                check_field("sum_below", out_word.sum_below, want_word.sum_below);
                check_field("total_bytes", out_word.total_bytes, want_word.total_bytes);
                check_field("is_empty", poel_pkg::t_total'(out_word.is_empty),
                            poel_pkg::t_total'(want_word.is_empty));
                check_field("status", poel_pkg::t_total'(out_word.status),
                            poel_pkg::t_total'(want_word.status));
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_phase             phase;
        poel_pkg::t_in_word w;
        int                 extra;
        int                 steps;
        bit                 max_sized;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int r = 0; r < DRILL_ROWS; r++) begin
            send_word(drill_rows[r].word, drill_rows[r].typed, drill_rows[r].want);
        end
        wait_quiet();

        // random phases until the word budget is spent
        while (words_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4: phase = PHASE_FILL;
                5, 6, 7: phase = PHASE_DRAIN;
                default: phase = PHASE_CHURN;
            endcase
            case (phase)
                PHASE_FILL: begin
                    // fill to capacity, then a few refused inserts;
                    // some fills use maximum sizes to push the total high
                    max_sized = ($urandom_range(0, 2) == 0);
                    extra     = $urandom_range(1, 3);
                    while (shadow_entries.size() < TABLE_DEPTH || extra > 0) begin
                        if (shadow_entries.size() >= TABLE_DEPTH) begin
                            extra--;
                        end
                        w.mode           = poel_pkg::MODE_INSERT;
                        w.entry_key      = pick_key(6);
                        w.entry_priority = pick_priority();
                        w.entry_bytes    = max_sized ? '1 : pick_bytes();
                        send_random(w);
                    end
                end
                PHASE_DRAIN: begin
                    // pop until empty, one more pop on the empty table
                    while (shadow_entries.size() > 0) begin
                        w        = '0;
                        w.mode   = poel_pkg::MODE_POP;
                        w.entry_key = $urandom;
                        send_random(w);
                    end
                    w      = '0;
                    w.mode = poel_pkg::MODE_POP;
                    send_random(w);
                end
                default: begin
                    steps = $urandom_range(20, 80);
                    repeat (steps) send_random(make_churn_word());
                end
            endcase
            // now and then the sender holds off until the list has caught up
            if ($urandom_range(0, 2) == 0) begin
                wait_quiet();
            end
        end

        wait_quiet();
        repeat (TABLE_DEPTH + 8) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // run limit
    initial begin
        #4_000_000;
        $display("timeout: %0d words sent, %0d results awaited", words_sent,
                 awaited_words.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire
